// File: sv/slrp_pkg.sv
// Package: section codes, status codes, result word type.
package slrp_pkg;
	typedef enum logic [3:0] {
		SEC_PROTO = 4'd0, SEC_ENC = 4'd1, SEC_VER = 4'd2, SEC_SRC = 4'd3,
		SEC_DST = 4'd4, SEC_CHAL = 4'd5, SEC_FILT = 4'd6, SEC_KEYS = 4'd7,
		SEC_OPT = 4'd8, SEC_IP = 4'd9, SEC_LIM = 4'd10, SEC_TRAIL = 4'd11,
		SEC_ERR = 4'd12
	} section_t;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_SHORT = 3'd1;
	localparam logic [2:0] ST_BAD_PROTO = 3'd2;
	localparam logic [2:0] ST_BAD_ENC = 3'd3;
	localparam logic [2:0] ST_BAD_KEY = 3'd4;
	localparam logic [2:0] ST_TOO_MANY = 3'd5;

	localparam logic [7:0] PROTO_BYTE = 8'h01;
	localparam logic [7:0] ENC_BYTE = 8'h03;
	localparam logic [7:0] BSLASH = 8'h5c;
	localparam logic [7:0] NUL = 8'h00;
	localparam logic [7:0] KEY_SAT = 8'd255;

	localparam logic CFG_ALT_IP = 1'b0;
	localparam logic CFG_LIMIT = 1'b1;

	typedef struct packed {
		logic        result_kind;
		logic [3:0]  section;
		logic [7:0]  key_index;
		logic        is_content;
		logic [7:0]  byte_echo;
		logic [2:0]  status;
		logic [31:0] game_version;
		logic [31:0] option_bits;
		logic [31:0] alt_source_ip;
		logic [31:0] result_limit;
		logic [7:0]  key_count;
		logic        last_result;
	} result_t;

	// queue entry: byte result and optional summary for one input word
	typedef struct packed {
		result_t byte_res;
		logic    has_sum;
		result_t sum_res;
	} entry_t;
endpackage

// File: sv/slrp_if.sv
// Interfaces: input byte channel, result channel, configuration write channel.
interface slrp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, data_byte, last_byte, input ready);
	modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface slrp_out_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [3:0]  section;
	logic [7:0]  key_index;
	logic        is_content;
	logic [7:0]  byte_echo;
	logic [2:0]  status;
	logic [31:0] game_version;
	logic [31:0] option_bits;
	logic [31:0] alt_source_ip;
	logic [31:0] result_limit;
	logic [7:0]  key_count;
	logic        last_result;
	modport source (output valid, result_kind, section, key_index, is_content, byte_echo,
		status, game_version, option_bits, alt_source_ip, result_limit, key_count,
		last_result, input ready);
	modport sink (input valid, result_kind, section, key_index, is_content, byte_echo,
		status, game_version, option_bits, alt_source_ip, result_limit, key_count,
		last_result, output ready);
endinterface

interface slrp_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: sv/slrp_front.sv
// Front: parse state machine that classifies each byte into a queue entry.
module slrp_front #(
	parameter int CHALLENGE_BYTES = 8,
	parameter int MAX_KEYS = 255,
	parameter int MIN_PACKET_BYTES = 26
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	input  logic [31:0]          alt_ip_mask,
	input  logic [31:0]          limit_mask,
	output slrp_pkg::entry_t     entry
);
	slrp_pkg::section_t sec_q, nxt;
	logic [3:0]  cnt_q, cnt_d;
	logic [4:0]  len_q, len_d;
	logic [31:0] shift_q, shift_d, ver_q, ver_d, opt_q, opt_d, ip_q, ip_d, lim_q, lim_d;
	logic [7:0]  keys_q, keys_d;
	logic [2:0]  err_q, err_d;
	logic        kst_q, kst_d;
	logic        content;
	logic [7:0]  kidx;
	logic [31:0] shifted;
	logic        full;
	logic [2:0]  status;

	always_comb begin
		nxt = sec_q;
		cnt_d = cnt_q;
		len_d = (32'(len_q) < MIN_PACKET_BYTES) ? len_q + 5'd1 : len_q;
		shift_d = shift_q; ver_d = ver_q; opt_d = opt_q; ip_d = ip_q; lim_d = lim_q;
		keys_d = keys_q; err_d = err_q; kst_d = kst_q;
		content = 1'b1;
		kidx = '0;
		shifted = {shift_q[23:0], data_byte};
		full = (cnt_q == 4'd3);
		case (sec_q)
			slrp_pkg::SEC_PROTO: begin
				if (data_byte != slrp_pkg::PROTO_BYTE) begin
					if (err_q == slrp_pkg::ST_OK) err_d = slrp_pkg::ST_BAD_PROTO;
					nxt = slrp_pkg::SEC_ERR;
				end else nxt = slrp_pkg::SEC_ENC;
			end
			slrp_pkg::SEC_ENC: begin
				if (data_byte != slrp_pkg::ENC_BYTE) begin
					if (err_q == slrp_pkg::ST_OK) err_d = slrp_pkg::ST_BAD_ENC;
					nxt = slrp_pkg::SEC_ERR;
				end else nxt = slrp_pkg::SEC_VER;
			end
			slrp_pkg::SEC_VER, slrp_pkg::SEC_OPT, slrp_pkg::SEC_IP, slrp_pkg::SEC_LIM: begin
				shift_d = shifted;
				cnt_d = full ? 4'd0 : cnt_q + 4'd1;
				if (full) begin
					shift_d = '0;
					case (sec_q)
						slrp_pkg::SEC_VER: begin
							ver_d = shifted; nxt = slrp_pkg::SEC_SRC;
						end
						slrp_pkg::SEC_OPT: begin
							opt_d = shifted;
							if ((shifted & alt_ip_mask) != '0) nxt = slrp_pkg::SEC_IP;
							else if ((shifted & limit_mask) != '0) nxt = slrp_pkg::SEC_LIM;
							else nxt = slrp_pkg::SEC_TRAIL;
						end
						slrp_pkg::SEC_IP: begin
							ip_d = shifted;
							nxt = ((opt_q & limit_mask) != '0) ? slrp_pkg::SEC_LIM
								: slrp_pkg::SEC_TRAIL;
						end
						default: begin
							lim_d = shifted; nxt = slrp_pkg::SEC_TRAIL;
						end
					endcase
				end
			end
			slrp_pkg::SEC_SRC, slrp_pkg::SEC_DST, slrp_pkg::SEC_FILT: begin
				if (data_byte == slrp_pkg::NUL) begin
					content = 1'b0;
					nxt = slrp_pkg::section_t'(sec_q + 4'd1);
				end
			end
			slrp_pkg::SEC_CHAL: begin
				if (data_byte == slrp_pkg::NUL) begin
					content = 1'b0;
					if (err_q == slrp_pkg::ST_OK) err_d = slrp_pkg::ST_SHORT;
					nxt = slrp_pkg::SEC_ERR;
				end else if (32'(cnt_q) + 1 >= CHALLENGE_BYTES) begin
					cnt_d = '0; nxt = slrp_pkg::SEC_FILT;
				end else cnt_d = cnt_q + 4'd1;
			end
			slrp_pkg::SEC_KEYS: begin
				if (!kst_q) begin
					content = 1'b0;
					if (data_byte == slrp_pkg::NUL) nxt = slrp_pkg::SEC_OPT;
					else if (data_byte != slrp_pkg::BSLASH) begin
						if (err_q == slrp_pkg::ST_OK) err_d = slrp_pkg::ST_BAD_KEY;
						nxt = slrp_pkg::SEC_ERR;
					end else kst_d = 1'b1;
				end else if (data_byte == slrp_pkg::NUL) begin
					content = 1'b0;
					if (32'(keys_q) >= MAX_KEYS) begin
						if (err_q == slrp_pkg::ST_OK) err_d = slrp_pkg::ST_TOO_MANY;
						nxt = slrp_pkg::SEC_ERR;
					end else nxt = slrp_pkg::SEC_OPT;
				end else if (data_byte == slrp_pkg::BSLASH) begin
					content = 1'b0;
					if (keys_q == 8'd0) keys_d = 8'd2;
					else if (keys_q != slrp_pkg::KEY_SAT) keys_d = keys_q + 8'd1;
				end else if (keys_q == 8'd0) keys_d = 8'd1;
				kidx = (keys_d != 8'd0) ? keys_d - 8'd1 : 8'd0;
			end
			slrp_pkg::SEC_TRAIL: content = 1'b0;
			default: begin
				content = 1'b0;
				nxt = slrp_pkg::SEC_ERR;
			end
		endcase

		if (32'(len_d) < MIN_PACKET_BYTES) status = slrp_pkg::ST_SHORT;
		else if (err_d != slrp_pkg::ST_OK) status = err_d;
		else if (nxt != slrp_pkg::SEC_TRAIL) status = slrp_pkg::ST_SHORT;
		else status = slrp_pkg::ST_OK;

		entry = '0;
		entry.byte_res.section = sec_q;
		entry.byte_res.key_index = kidx;
		entry.byte_res.is_content = content;
		entry.byte_res.byte_echo = data_byte;
		entry.byte_res.last_result = ~last_byte;
		entry.has_sum = last_byte;
		entry.sum_res.result_kind = 1'b1;
		entry.sum_res.section = nxt;
		entry.sum_res.status = status;
		entry.sum_res.game_version = ver_d;
		entry.sum_res.option_bits = opt_d;
		entry.sum_res.alt_source_ip = ip_d;
		entry.sum_res.result_limit = lim_d;
		entry.sum_res.key_count = keys_d;
		entry.sum_res.last_result = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q <= slrp_pkg::SEC_PROTO;
			cnt_q <= '0; len_q <= '0; shift_q <= '0; ver_q <= '0; opt_q <= '0;
			ip_q <= '0; lim_q <= '0; keys_q <= '0; err_q <= '0; kst_q <= 1'b0;
		end else if (take) begin
			if (last_byte) begin
				sec_q <= slrp_pkg::SEC_PROTO;
				cnt_q <= '0; len_q <= '0; shift_q <= '0; ver_q <= '0; opt_q <= '0;
				ip_q <= '0; lim_q <= '0; keys_q <= '0; err_q <= '0; kst_q <= 1'b0;
			end else begin
				sec_q <= nxt;
				cnt_q <= cnt_d; len_q <= len_d; shift_q <= shift_d; ver_q <= ver_d;
				opt_q <= opt_d; ip_q <= ip_d; lim_q <= lim_d; keys_q <= keys_d;
				err_q <= err_d; kst_q <= kst_d;
			end
		end
	end
endmodule

// File: sv/slrp_queue.sv
// Two-entry queue between front and back.
module slrp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  slrp_pkg::entry_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output slrp_pkg::entry_t head
);
	slrp_pkg::entry_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// File: sv/slrp_back.sv
// Back: issues the byte word, then the summary word if the entry has one.
module slrp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  slrp_pkg::entry_t  head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output slrp_pkg::result_t out_res
);
	logic phase_q;
	logic fire;

	assign out_valid = !empty;
	assign out_res = phase_q ? head.sum_res : head.byte_res;
	assign fire = out_valid && out_ready;
	assign pop = fire && (phase_q || !head.has_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) phase_q <= 1'b0;
		else if (fire) phase_q <= !pop;
	end
endmodule

// File: sv/server_list_request_parser_unit.sv
// Top level: server list request parser.
// Bytes of a request packet arrive on the in channel, one word per byte, with
// last_byte on the final one. Each byte yields one result word on the out
// channel with its section, key index and content flag; the final byte yields
// a second word, the summary with status, gathered words and key count.
// Configuration writes on cfg set the alternate address mask (index 0) and the
// limit mask (index 1); cfg is always ready.
// The front parses one byte per cycle while the queue is not full into a
// two-entry queue; the back drains it. Result words are registered in the
// queue; a last byte's entry is popped only once both its words are taken.
// When the receiver stalls the queue fills; in.ready drops at two entries.
// Reset clears the parse state, empties the queue and restores the masks to
// 8 and 128.
module server_list_request_parser_unit #(
	parameter int CHALLENGE_BYTES = 8,
	parameter int MAX_KEYS = 255,
	parameter int MIN_PACKET_BYTES = 26
) (
	input logic        clk,
	input logic        arst_n,
	slrp_in_if.sink    in,
	slrp_out_if.source out,
	slrp_cfg_if.sink   cfg
);
	logic [31:0] alt_q, lim_q;
	slrp_pkg::entry_t ent, head;
	slrp_pkg::result_t res;
	logic full, empty, pop, take;

	assign in.ready = !full;
	assign cfg.ready = 1'b1;
	assign take = in.valid && in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_q <= 32'd8; lim_q <= 32'd128;
		end else if (cfg.valid) begin
			if (cfg.index == slrp_pkg::CFG_ALT_IP) alt_q <= cfg.data;
			else lim_q <= cfg.data;
		end
	end

	slrp_front #(.CHALLENGE_BYTES(CHALLENGE_BYTES), .MAX_KEYS(MAX_KEYS),
		.MIN_PACKET_BYTES(MIN_PACKET_BYTES)) u_front (
		.clk, .arst_n, .take, .data_byte(in.data_byte), .last_byte(in.last_byte),
		.alt_ip_mask(alt_q), .limit_mask(lim_q), .entry(ent));

	slrp_queue u_queue (.clk, .arst_n, .push(take), .push_data(ent), .full,
		.pop, .empty, .head);

	slrp_back u_back (.clk, .arst_n, .empty, .head, .pop, .out_valid(out.valid),
		.out_ready(out.ready), .out_res(res));

	assign out.result_kind = res.result_kind;
	assign out.section = res.section;
	assign out.key_index = res.key_index;
	assign out.is_content = res.is_content;
	assign out.byte_echo = res.byte_echo;
	assign out.status = res.status;
	assign out.game_version = res.game_version;
	assign out.option_bits = res.option_bits;
	assign out.alt_source_ip = res.alt_source_ip;
	assign out.result_limit = res.result_limit;
	assign out.key_count = res.key_count;
	assign out.last_result = res.last_result;
endmodule

// File: sv/slrp_checker.sv
// Checker on the top level ports, with its bind.
module slrp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       out_kind,
	input logic       out_last,
	input logic [3:0] out_section,
	input logic [2:0] out_status
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result word dropped");
	a_sum_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind |-> out_last) else $error("summary not last");
	a_sum_sec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_kind |-> out_status == 3'd0) else $error("status in byte word");
	a_sec_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_section <= 4'd12) else $error("section out of range");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("stall with empty output");
endmodule

bind server_list_request_parser_unit slrp_checker u_slrp_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in.valid), .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready), .out_kind(out.result_kind),
	.out_last(out.last_result), .out_section(out.section), .out_status(out.status));

// File: tb/tb_server_list_request_parser_unit.sv
// Testbench for the server list request parser: random packets, field checks.
module tb_server_list_request_parser_unit;
	localparam int CHAL_LEN = 8;
	localparam int KEY_LIMIT = 255;
	localparam int MIN_LEN = 26;

	logic clk;
	logic arst_n;

	slrp_in_if in_ch();
	slrp_out_if out_ch();
	slrp_cfg_if cfg_ch();

	server_list_request_parser_unit uut (
		.clk(clk), .arst_n(arst_n), .in(in_ch.sink), .out(out_ch.source), .cfg(cfg_ch.sink)
	);

	class parse_scoreboard;
		logic [31:0]        ip_mask, lim_mask;
		slrp_pkg::section_t cur;
		logic [3:0]         cnt;
		logic [4:0]         tlen;
		logic [31:0]        shift_w, ver_w, opt_w, addr_w, lim_w;
		logic [7:0]         keys;
		logic [2:0]         ferr;
		logic               started;
		slrp_pkg::result_t  pending[$];
		int                 errors;
		int                 checked;
		int                 packets;
		int                 status_seen[8];

		function new();
			ip_mask = 32'd8;
			lim_mask = 32'd128;
			errors = 0;
			checked = 0;
			packets = 0;
			clear();
		endfunction

		function void clear();
			cur = slrp_pkg::SEC_PROTO;
			cnt = '0;
			tlen = '0;
			shift_w = '0;
			ver_w = '0;
			opt_w = '0;
			addr_w = '0;
			lim_w = '0;
			keys = '0;
			ferr = slrp_pkg::ST_OK;
			started = 1'b0;
		endfunction

		function void flag(logic [2:0] code);
			if (ferr == slrp_pkg::ST_OK)
				ferr = code;
		endfunction

		function bit gather(logic [7:0] b);
			shift_w = {shift_w[23:0], b};
			cnt = cnt + 4'd1;
			if (cnt >= 4'd4) begin
				cnt = '0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		// work out the words caused by one accepted byte
		function void note_byte(logic [7:0] b, logic lst);
			slrp_pkg::result_t  r;
			slrp_pkg::result_t  s;
			slrp_pkg::section_t sec;
			slrp_pkg::section_t nx;
			logic               content;
			logic [7:0]         kidx;
			logic [2:0]         st;
			sec = cur;
			nx = cur;
			content = 1'b1;
			kidx = '0;
			if (tlen < MIN_LEN)
				tlen = tlen + 5'd1;
			case (sec)
				slrp_pkg::SEC_PROTO: begin
					if (b != slrp_pkg::PROTO_BYTE) begin
						flag(slrp_pkg::ST_BAD_PROTO);
						nx = slrp_pkg::SEC_ERR;
					end else
						nx = slrp_pkg::SEC_ENC;
				end
				slrp_pkg::SEC_ENC: begin
					if (b != slrp_pkg::ENC_BYTE) begin
						flag(slrp_pkg::ST_BAD_ENC);
						nx = slrp_pkg::SEC_ERR;
					end else
						nx = slrp_pkg::SEC_VER;
				end
				slrp_pkg::SEC_VER: begin
					if (gather(b)) begin
						ver_w = shift_w;
						shift_w = '0;
						nx = slrp_pkg::SEC_SRC;
					end
				end
				slrp_pkg::SEC_SRC, slrp_pkg::SEC_DST, slrp_pkg::SEC_FILT: begin
					if (b == slrp_pkg::NUL) begin
						content = 1'b0;
						nx = slrp_pkg::section_t'(sec + 4'd1);
					end
				end
				slrp_pkg::SEC_CHAL: begin
					if (b == slrp_pkg::NUL) begin
						content = 1'b0;
						flag(slrp_pkg::ST_SHORT);
						nx = slrp_pkg::SEC_ERR;
					end else begin
						cnt = cnt + 4'd1;
						if (cnt >= CHAL_LEN) begin
							cnt = '0;
							nx = slrp_pkg::SEC_FILT;
						end
					end
				end
				slrp_pkg::SEC_KEYS: begin
					if (!started) begin
						content = 1'b0;
						if (b == slrp_pkg::NUL)
							nx = slrp_pkg::SEC_OPT;
						else if (b != slrp_pkg::BSLASH) begin
							flag(slrp_pkg::ST_BAD_KEY);
							nx = slrp_pkg::SEC_ERR;
						end else
							started = 1'b1;
					end else if (b == slrp_pkg::NUL) begin
						content = 1'b0;
						if (keys >= KEY_LIMIT) begin
							flag(slrp_pkg::ST_TOO_MANY);
							nx = slrp_pkg::SEC_ERR;
						end else
							nx = slrp_pkg::SEC_OPT;
					end else if (b == slrp_pkg::BSLASH) begin
						content = 1'b0;
						if (keys == 0)
							keys = 8'd2;
						else if (keys != slrp_pkg::KEY_SAT)
							keys = keys + 8'd1;
					end else if (keys == 0)
						keys = 8'd1;
					kidx = (keys != 0) ? keys - 8'd1 : 8'd0;
				end
				slrp_pkg::SEC_OPT: begin
					if (gather(b)) begin
						opt_w = shift_w;
						shift_w = '0;
						if ((opt_w & ip_mask) != 0)
							nx = slrp_pkg::SEC_IP;
						else if ((opt_w & lim_mask) != 0)
							nx = slrp_pkg::SEC_LIM;
						else
							nx = slrp_pkg::SEC_TRAIL;
					end
				end
				slrp_pkg::SEC_IP: begin
					if (gather(b)) begin
						addr_w = shift_w;
						shift_w = '0;
						nx = ((opt_w & lim_mask) != 0) ? slrp_pkg::SEC_LIM
							: slrp_pkg::SEC_TRAIL;
					end
				end
				slrp_pkg::SEC_LIM: begin
					if (gather(b)) begin
						lim_w = shift_w;
						shift_w = '0;
						nx = slrp_pkg::SEC_TRAIL;
					end
				end
				slrp_pkg::SEC_TRAIL: content = 1'b0;
				default: begin
					content = 1'b0;
					nx = slrp_pkg::SEC_ERR;
				end
			endcase
			cur = nx;
			r = '0;
			r.section = sec;
			r.key_index = kidx;
			r.is_content = content;
			r.byte_echo = b;
			r.last_result = !lst;
			pending.push_back(r);
			if (!lst)
				return;
			if (tlen < MIN_LEN)
				st = slrp_pkg::ST_SHORT;
			else if (ferr != slrp_pkg::ST_OK)
				st = ferr;
			else if (cur != slrp_pkg::SEC_TRAIL)
				st = slrp_pkg::ST_SHORT;
			else
				st = slrp_pkg::ST_OK;
			s = '0;
			s.result_kind = 1'b1;
			s.section = cur;
			s.status = st;
			s.game_version = ver_w;
			s.option_bits = opt_w;
			s.alt_source_ip = addr_w;
			s.result_limit = lim_w;
			s.key_count = keys;
			s.last_result = 1'b1;
			pending.push_back(s);
			status_seen[st]++;
			packets++;
			clear();
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("MISMATCH %s: got %0h, expected %0h", what, got, want);
		endtask

		task cmp(string what, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report(what, got, want);
		endtask

		task check_result(slrp_pkg::result_t got);
			slrp_pkg::result_t w;
			if (pending.size() == 0) begin
				report("unexpected word", 32'(got.byte_echo), 32'd0);
				return;
			end
			w = pending.pop_front();
			checked++;
			cmp("result_kind", 32'(got.result_kind), 32'(w.result_kind));
			cmp("section", 32'(got.section), 32'(w.section));
			cmp("key_index", 32'(got.key_index), 32'(w.key_index));
			cmp("is_content", 32'(got.is_content), 32'(w.is_content));
			cmp("byte_echo", 32'(got.byte_echo), 32'(w.byte_echo));
			cmp("status", 32'(got.status), 32'(w.status));
			cmp("game_version", got.game_version, w.game_version);
			cmp("option_bits", got.option_bits, w.option_bits);
			cmp("alt_source_ip", got.alt_source_ip, w.alt_source_ip);
			cmp("result_limit", got.result_limit, w.result_limit);
			cmp("key_count", 32'(got.key_count), 32'(w.key_count));
			cmp("last_result", 32'(got.last_result), 32'(w.last_result));
		endtask
	endclass

	parse_scoreboard sb;
	int idle_pct;
	int stall_pct;
	int hold_left;
	int bytes_sent;
	logic [7:0] pkt[$];

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// receiver: random stalls, plus a long hold when asked
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// sample at the falling edge; the word moves at the next rising edge
	always @(negedge clk) begin
		slrp_pkg::result_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.result_kind = out_ch.result_kind;
			got.section = out_ch.section;
			got.key_index = out_ch.key_index;
			got.is_content = out_ch.is_content;
			got.byte_echo = out_ch.byte_echo;
			got.status = out_ch.status;
			got.game_version = out_ch.game_version;
			got.option_bits = out_ch.option_bits;
			got.alt_source_ip = out_ch.alt_source_ip;
			got.result_limit = out_ch.result_limit;
			got.key_count = out_ch.key_count;
			got.last_result = out_ch.last_result;
			sb.check_result(got);
		end
	end

	task send_byte(logic [7:0] b, logic lst);
		bit taken;
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.last_byte <= lst;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = in_ch.ready;
			if (taken)
				sb.note_byte(b, lst);
			@(posedge clk);
		end
		bytes_sent++;
	endtask

	task send_packet();
		foreach (pkt[i])
			send_byte(pkt[i], i == pkt.size() - 1);
	endtask

	task drain();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_reg(logic idx, logic [31:0] val);
		bit taken;
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = cfg_ch.ready;
			@(posedge clk);
		end
		cfg_ch.valid <= 1'b0;
		if (idx == slrp_pkg::CFG_ALT_IP)
			sb.ip_mask = val;
		else
			sb.lim_mask = val;
	endtask

	function logic [7:0] plain_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while (c == slrp_pkg::NUL || c == slrp_pkg::BSLASH);
		return c;
	endfunction

	task push_word(logic [31:0] w);
		for (int i = 3; i >= 0; i--)
			pkt.push_back(w[i*8 +: 8]);
	endtask

	// build one request, mostly well formed, sometimes damaged
	task build_packet();
		int n;
		int k;
		logic [31:0] opt;
		pkt.delete();
		if ($urandom_range(99) < 5) begin
			n = $urandom_range(40, 1);
			repeat (n) pkt.push_back(8'($urandom_range(255)));
			return;
		end
		pkt.push_back(slrp_pkg::PROTO_BYTE);
		pkt.push_back(slrp_pkg::ENC_BYTE);
		push_word($urandom());
		repeat (2) begin
			n = $urandom_range(3);
			repeat (n) pkt.push_back(plain_char());
			pkt.push_back(slrp_pkg::NUL);
		end
		repeat (CHAL_LEN) pkt.push_back(8'($urandom_range(255, 1)));
		n = $urandom_range(3);
		repeat (n) pkt.push_back(plain_char());
		pkt.push_back(slrp_pkg::NUL);
		case ($urandom_range(9))
			0: ;
			1: pkt.push_back(slrp_pkg::BSLASH);
			2: repeat (KEY_LIMIT + 2) pkt.push_back(slrp_pkg::BSLASH);
			default: begin
				k = $urandom_range(4, 1);
				repeat (k) begin
					pkt.push_back(slrp_pkg::BSLASH);
					n = $urandom_range(3);
					repeat (n) pkt.push_back(plain_char());
				end
			end
		endcase
		pkt.push_back(slrp_pkg::NUL);
		opt = $urandom();
		opt = ($urandom_range(1)) ? (opt | sb.ip_mask) : (opt & ~sb.ip_mask);
		opt = ($urandom_range(1)) ? (opt | sb.lim_mask) : (opt & ~sb.lim_mask);
		push_word(opt);
		if ((opt & sb.ip_mask) != 0)
			push_word($urandom());
		if ((opt & sb.lim_mask) != 0)
			push_word($urandom());
		n = $urandom_range(2);
		repeat (n) pkt.push_back(8'($urandom_range(255)));
		if ($urandom_range(99) < 15)
			pkt[$urandom_range(pkt.size() - 1)] = 8'($urandom_range(255));
		if ($urandom_range(99) < 10) begin
			n = $urandom_range(pkt.size() - 1, 1);
			while (pkt.size() > n)
				void'(pkt.pop_back());
		end
	endtask

	task run_phase(int idle, int stall, int quota);
		int target;
		idle_pct = idle;
		stall_pct = stall;
		target = bytes_sent + quota;
		while (bytes_sent < target) begin
			build_packet();
			send_packet();
		end
		in_ch.valid <= 1'b0;
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.last_byte = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = slrp_pkg::CFG_ALT_IP;
		cfg_ch.data = '0;
		out_ch.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		bytes_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// shortest valid request: empty key list, address present
		pkt = '{slrp_pkg::PROTO_BYTE, slrp_pkg::ENC_BYTE, 8'hff, 8'hff, 8'hff, 8'hff,
			slrp_pkg::NUL, slrp_pkg::NUL,
			8'hff, 8'h80, 8'h7f, 8'h01, 8'hfe, 8'h55, 8'haa, 8'h5c,
			slrp_pkg::NUL, slrp_pkg::NUL,
			8'h00, 8'h00, 8'h00, 8'h08, 8'hde, 8'had, 8'hbe, 8'hef};
		send_packet();
		pkt = '{8'h02};
		send_packet();

		run_phase(0, 0, 300);
		write_reg(slrp_pkg::CFG_ALT_IP, 32'h0);
		write_reg(slrp_pkg::CFG_LIMIT, 32'h0);
		run_phase(76, 0, 300);
		write_reg(slrp_pkg::CFG_ALT_IP, 32'hffff_ffff);
		write_reg(slrp_pkg::CFG_LIMIT, 32'hffff_ffff);
		run_phase(0, 76, 300);
		write_reg(slrp_pkg::CFG_ALT_IP, $urandom());
		write_reg(slrp_pkg::CFG_LIMIT, $urandom());
		run_phase(30, 30, 300);

		// hold the receiver off while bytes keep coming, then restore defaults
		@(negedge clk);
		hold_left = 60;
		@(posedge clk);
		run_phase(0, 0, 40);
		write_reg(slrp_pkg::CFG_ALT_IP, 32'd8);
		write_reg(slrp_pkg::CFG_LIMIT, 32'd128);
		run_phase(0, 0, 300);

		drain();
		repeat (10) @(posedge clk);
		$display("Checked %0d words over %0d packets (%0d bytes).",
			sb.checked, sb.packets, bytes_sent);
		$display("Summaries: ok %0d, short %0d, protocol %0d, encoding %0d, key %0d, count %0d",
			sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
			sb.status_seen[4], sb.status_seen[5]);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#4000000;
		$display("Timeout");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// File: server_list_request_parser_unit.f
sv/slrp_pkg.sv
sv/slrp_if.sv
sv/slrp_front.sv
sv/slrp_queue.sv
sv/slrp_back.sv
sv/server_list_request_parser_unit.sv
sv/slrp_checker.sv
tb/tb_server_list_request_parser_unit.sv
